### hdl/osts_pkg.sv
// ----------------------------------------------------------------------------
// osts_pkg
// Shared types and codes for the one-shot timer slot table.
// ----------------------------------------------------------------------------
package osts_pkg;

  localparam int SpanW  = 32;
  localparam int OwnerW = 8;
  localparam int TagW   = 16;
  localparam int TimeW  = 48;
  localparam int KindW  = 2;

  // input selector carried on tuser
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds carried on tuser
  localparam logic [KindW-1:0] KIND_ARM    = 2'd0;
  localparam logic [KindW-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KindW-1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic [SpanW-1:0]  span;
    logic [OwnerW-1:0] owner;
    logic [TagW-1:0]   tag;
  } slot_entry_t;

  // write strobes from the sequencer to the slot memory
  typedef struct packed {
    logic span_en;
    logic meta_en;
  } slot_wr_t;

endpackage

### hdl/osts_slot_mem.sv
// ----------------------------------------------------------------------------
// osts_slot_mem
// Slot storage: span memory with per-slot valid bits plus owner/tag memory,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module osts_slot_mem #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  osts_pkg::slot_wr_t   wr,
  input  logic [IW-1:0]        wr_addr,
  input  osts_pkg::slot_entry_t wr_data,
  input  logic [IW-1:0]        rd_addr,
  output osts_pkg::slot_entry_t rd_data
);

  logic [osts_pkg::SpanW-1:0]                    span_mem [SLOTS];
  logic [osts_pkg::OwnerW+osts_pkg::TagW-1:0]    meta_mem [SLOTS];
  logic [SLOTS-1:0]                              valid;
  logic [osts_pkg::SpanW-1:0]                    span_q;
  logic [osts_pkg::OwnerW+osts_pkg::TagW-1:0]    meta_q;
  logic                                          vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.span_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.span_en) begin
      span_mem[wr_addr] <= wr_data.span;
    end
    if (wr.meta_en) begin
      meta_mem[wr_addr] <= {wr_data.owner, wr_data.tag};
    end
    span_q <= span_mem[rd_addr];
    meta_q <= meta_mem[rd_addr];
    vld_q  <= valid[rd_addr];
  end

  // a slot never written reads as free
  assign rd_data.span  = vld_q ? span_q : '0;
  assign rd_data.owner = meta_q[osts_pkg::OwnerW+osts_pkg::TagW-1:osts_pkg::TagW];
  assign rd_data.tag   = meta_q[osts_pkg::TagW-1:0];

endmodule

### hdl/one_shot_timer_slot_table.sv
// ----------------------------------------------------------------------------
// one_shot_timer_slot_table
// Table of one-shot timers: arm words claim the first free slot, tick words
// count down every busy slot and report the ones that expire.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               tuser          tdata / tlast
//  s_axis   in   s_axis_tvalid/tready    opcode         owner, span, tag
//  m_axis   out  m_axis_tvalid/tready    kind           accepted, owner, tag,
//                                                       run_time; tlast=last
//
//  each word passes an accept state, a read-modify-write walk over every slot
//  of the memory, and a closing state.
//  a new word is taken only after the closing cycle of the previous one.
//  reset clears the slot valid bits at once, so there is no clearing pass.
//  a stalled output holds the walk on the slot that expires.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // owner_task[7:0], span_ticks[39:8], timer_tag[55:40]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // accepted[0], expired_owner[8:1], expired_tag[24:9],
                                      // run_time[72:25], zero[79:73]
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  typedef enum logic [1:0] {IDLE, WALK, FIN} state_t;

  state_t                         state;
  logic [IW-1:0]                  idx;
  logic                           op;
  logic [osts_pkg::OwnerW-1:0]    arg_owner;
  logic [osts_pkg::SpanW-1:0]     arg_span;
  logic [osts_pkg::TagW-1:0]      arg_tag;
  logic                           found;
  logic [IW-1:0]                  fidx;
  logic [osts_pkg::TimeW-1:0]     tick_total;

  logic                           out_valid;
  logic [osts_pkg::KindW-1:0]     out_kind;
  logic                           out_acc;
  logic [osts_pkg::OwnerW-1:0]    out_owner;
  logic [osts_pkg::TagW-1:0]      out_tag;
  logic [osts_pkg::TimeW-1:0]     out_time;
  logic                           out_last;

  osts_pkg::slot_wr_t             wr;
  logic [IW-1:0]                  wr_addr;
  osts_pkg::slot_entry_t          wr_data;
  logic [IW-1:0]                  rd_addr;
  osts_pkg::slot_entry_t          cur;

  logic                           can_push;
  logic                           cur_busy;
  logic [osts_pkg::SpanW-1:0]     span_dec;
  logic                           hit;
  logic                           advance;
  logic                           fin_go;
  logic                           push;

  osts_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (cur)
  );

  assign can_push = !out_valid || m_axis_tready;
  assign cur_busy = (cur.span != '0);
  assign span_dec = cur.span - osts_pkg::SpanW'(1);
  assign hit      = (op == osts_pkg::OP_TICK) && cur_busy && (span_dec == '0);
  assign advance  = (state == WALK) && (!hit || can_push);
  assign fin_go   = (state == FIN) && can_push;
  assign push     = (advance && hit) || fin_go;

  // read address points at the slot handled in the next cycle, else at slot 0
  always_comb begin
    if (advance && idx != LastIdx) begin
      rd_addr = idx + IW'(1);
    end else if (state == WALK && !advance) begin
      rd_addr = idx;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    wr.span_en = 1'b0;
    wr.meta_en = 1'b0;
    wr_addr    = idx;
    wr_data    = '{span: span_dec, owner: cur.owner, tag: cur.tag};
    if (state == FIN) begin
      wr_addr    = fidx;
      wr_data    = '{span: arg_span, owner: arg_owner, tag: arg_tag};
      wr.span_en = fin_go && (op == osts_pkg::OP_ARM) && found;
      wr.meta_en = wr.span_en;
    end else if (advance && op == osts_pkg::OP_TICK && cur_busy) begin
      wr.span_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      idx        <= '0;
      found      <= 1'b0;
      tick_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            op        <= s_axis_tuser;
            arg_owner <= s_axis_tdata[7:0];
            arg_span  <= s_axis_tdata[39:8];
            arg_tag   <= s_axis_tdata[55:40];
            idx       <= '0;
            found     <= 1'b0;
            if (s_axis_tuser == osts_pkg::OP_TICK) begin
              tick_total <= tick_total + osts_pkg::TimeW'(1);
            end
            state <= WALK;
          end
        end
        WALK: begin
          if (advance) begin
            if (op == osts_pkg::OP_ARM && !found && !cur_busy) begin
              found <= 1'b1;
              fidx  <= idx;
            end
            if (hit) begin
              out_kind  <= osts_pkg::KIND_EXPIRY;
              out_acc   <= 1'b0;
              out_owner <= cur.owner;
              out_tag   <= cur.tag;
              out_time  <= '0;
              out_last  <= 1'b0;
            end
            if (idx == LastIdx) begin
              state <= FIN;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        FIN: begin
          if (can_push) begin
            out_owner <= '0;
            out_tag   <= '0;
            out_last  <= 1'b1;
            if (op == osts_pkg::OP_ARM) begin
              out_kind <= osts_pkg::KIND_ARM;
              out_acc  <= found;
              out_time <= '0;
            end else begin
              out_kind <= osts_pkg::KIND_DONE;
              out_acc  <= 1'b0;
              out_time <= tick_total;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, out_time, out_tag, out_owner, out_acc};

endmodule
